/* rtl/obp_pkg.sv */
// Shared types, code tables and code-building functions for the object-code bit packer.
// Used by every module of the block; depends on nothing.
package obp_pkg;

    localparam int STOCK_W     = 27;
    localparam int CHUNK_W     = 25;
    localparam int LEN_W       = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    localparam logic [1:0] KIND_ITEM  = 2'd0;
    localparam logic [1:0] KIND_RAW   = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;
    localparam logic [1:0] KIND_SKIP  = 2'd3;

    localparam logic [13:0] ESCAPE_CODE = 14'd7295;
    localparam logic [13:0] OP85_CODE   = 14'd5127;
    localparam logic [13:0] OP_HIGH_BASE = 14'd10599;
    localparam logic [6:0]  OP_TABLE_FIRST = 7'd8;
    localparam logic [6:0]  OP_TABLE_LAST  = 7'd61;
    localparam logic [6:0]  OP_SPECIAL     = 7'd85;
    localparam logic [3:0]  RAW_MAX_LEN    = 4'd10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  opcode;
        logic [26:0] word;
        logic [3:0]  code_length;
        logic [9:0]  code_bits;
    } in_item_t;

    typedef struct packed {
        logic [26:0] data;
        logic        last;
    } out_item_t;

    typedef enum logic [0:0] {
        ENT_CHUNK = 1'b0,
        ENT_FLUSH = 1'b1
    } entry_op_t;

    // One unit of work for the back end: a run of code bits, or a flush.
    typedef struct packed {
        entry_op_t          op;
        logic [LEN_W-1:0]   len;
        logic [CHUNK_W-1:0] bits;
        logic               fin;
    } entry_t;

    localparam logic [26:0] PAIR_KEY [19] = '{
        27'd21495808, 27'd71827459, 27'd88080386, 27'd71827456, 27'd4718592,
        27'd71303170, 27'd88604673, 27'd0,        27'd524291,   27'd88178690,
        27'd71827457, 27'd1048577,  27'd20971522, 27'd4784128,  27'd8388608,
        27'd4390912,  27'd13172736, 27'd1572865,  27'd524288
    };

    localparam logic [13:0] PAIR_CODE [19] = '{
        14'd3076, 14'd3077, 14'd4108, 14'd4109, 14'd7280, 14'd7281, 14'd7282,
        14'd7283, 14'd7284, 14'd7285, 14'd7286, 14'd7287, 14'd7288, 14'd7289,
        14'd7290, 14'd7291, 14'd7292, 14'd7293, 14'd7294
    };

    // Codes for opcodes 8 through 61, indexed by opcode minus 8.
    localparam logic [13:0] OP_CODE [54] = '{
        14'd10624, 14'd6160,  14'd10625, 14'd10626, 14'd10627, 14'd7208,
        14'd6161,  14'd10628, 14'd5124,  14'd7209,  14'd6162,  14'd7210,
        14'd7211,  14'd10629, 14'd10630, 14'd10631, 14'd10632, 14'd10633,
        14'd10634, 14'd10635, 14'd10636, 14'd10637, 14'd6163,  14'd7212,
        14'd10638, 14'd4096,  14'd4097,  14'd7213,  14'd10639, 14'd10640,
        14'd10641, 14'd7214,  14'd10642, 14'd10643, 14'd10644, 14'd10645,
        14'd10646, 14'd10647, 14'd10648, 14'd10649, 14'd10650, 14'd10651,
        14'd10652, 14'd10653, 14'd10654, 14'd10655, 14'd10656, 14'd10657,
        14'd5125,  14'd10658, 14'd5126,  14'd10659, 14'd10660, 14'd7215
    };

    // Codes of the three 5-bit address parts joined into one bit run.
    // Result is {length, bits}; every code fits inside its own length.
    function automatic logic [22:0] addr_trio(input logic [14:0] a);
        logic [3:0]  l1;
        logic [3:0]  l2;
        logic [3:0]  l3;
        logic [5:0]  b1;
        logic [5:0]  b2;
        logic [5:0]  b3;
        logic [3:0]  off3;
        logic [17:0] bits;
        logic [4:0]  len;
        case (a[4:0])
            5'd1:    begin l1 = 4'd2; b1 = 6'd0; end
            5'd2:    begin l1 = 4'd3; b1 = 6'd2; end
            5'd3:    begin l1 = 4'd3; b1 = 6'd3; end
            default: begin l1 = 4'd6; b1 = {1'b1, a[4:0]}; end
        endcase
        case (a[9:5])
            5'd0:    begin l2 = 4'd2; b2 = 6'd0; end
            5'd1:    begin l2 = 4'd4; b2 = 6'd4; end
            5'd2:    begin l2 = 4'd4; b2 = 6'd5; end
            5'd4:    begin l2 = 4'd4; b2 = 6'd6; end
            5'd5:    begin l2 = 4'd4; b2 = 6'd7; end
            default: begin l2 = 4'd6; b2 = {1'b1, a[9:5]}; end
        endcase
        case (a[14:10])
            5'd0:    begin l3 = 4'd1; b3 = 6'd0; end
            default: begin l3 = 4'd6; b3 = {1'b1, a[14:10]}; end
        endcase
        off3 = l1 + l2;
        bits = 18'(b1) | (18'(b2) << l1) | (18'(b3) << off3);
        len  = 5'(l1) + 5'(l2) + 5'(l3);
        return {len, bits};
    endfunction

    // Table match on the opcode and the upper word; result is {hit, code}.
    function automatic logic [14:0] pair_lookup(input logic [26:0] key);
        logic        hit;
        logic [13:0] code;
        hit  = 1'b0;
        code = '0;
        for (int i = 0; i < 19; i++)
        begin
            if (key == PAIR_KEY[i])
            begin
                hit  = 1'b1;
                code = PAIR_CODE[i];
            end
        end
        return {hit, code};
    endfunction

endpackage

/* rtl/obp_front.sv */
// Front end: accepts items, classifies them and turns each into up to two entries.
// Depends on obp_pkg; feeds obp_queue.
module obp_front import obp_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     q_full,
    output logic     push,
    output entry_t   push_entry
);

    logic       pend_valid_reg;
    logic       pend_valid_next;
    entry_t     pend_entry_reg;
    entry_t     pend_entry_next;

    logic       accept;
    logic [22:0] trio1;
    logic [22:0] trio2;
    logic [14:0] pair;
    logic [26:0] key;
    logic [13:0] op_code;
    logic [5:0]  op_index;
    logic [4:0]  trio1_len;
    logic [4:0]  trio2_len;
    logic [3:0]  raw_len;
    entry_t      first;
    entry_t      second;
    logic        split;

    assign in_stall = pend_valid_reg || q_full;
    assign accept   = in_valid && !in_stall;

    assign trio1     = addr_trio(in_item.word[14:0]);
    assign trio2     = addr_trio({in_item.opcode[2:0], in_item.word[26:15]});
    assign trio1_len = trio1[22:18];
    assign trio2_len = trio2[22:18];
    assign key       = {in_item.word[26:15], 12'd0, in_item.opcode[2:0]};
    assign pair      = pair_lookup(key);
    assign op_index  = 6'(in_item.opcode - OP_TABLE_FIRST);
    assign raw_len   = (in_item.code_length > RAW_MAX_LEN) ? RAW_MAX_LEN : in_item.code_length;

    always_comb
    begin
        if (in_item.opcode >= OP_TABLE_FIRST && in_item.opcode <= OP_TABLE_LAST)
        begin
            op_code = OP_CODE[op_index];
        end
        else if (in_item.opcode == OP_SPECIAL)
        begin
            op_code = OP85_CODE;
        end
        else
        begin
            op_code = 14'(in_item.opcode) + OP_HIGH_BASE;
        end
    end

    always_comb
    begin
        first  = '{op: ENT_CHUNK, len: '0, bits: '0, fin: 1'b1};
        second = '{op: ENT_CHUNK, len: '0, bits: '0, fin: 1'b1};
        split  = 1'b0;
        case (in_item.kind)
            KIND_ITEM:
            begin
                if (in_item.opcode < OP_TABLE_FIRST)
                begin
                    if (pair[14])
                    begin
                        first.bits = 25'(trio1[17:0]) | (25'(pair[9:0]) << trio1_len);
                        first.len  = trio1_len + 5'(pair[13:10]);
                    end
                    else
                    begin
                        // No table match: second address plus the escape code follow.
                        split       = 1'b1;
                        first.bits  = 25'(trio1[17:0]);
                        first.len   = trio1_len;
                        first.fin   = 1'b0;
                        second.bits = 25'(trio2[17:0]) | (25'(ESCAPE_CODE[9:0]) << trio2_len);
                        second.len  = trio2_len + 5'(ESCAPE_CODE[13:10]);
                    end
                end
                else
                begin
                    first.bits = 25'(op_code[9:0]);
                    first.len  = 5'(op_code[13:10]);
                end
            end
            KIND_RAW:
            begin
                first.bits = 25'(in_item.code_bits);
                first.len  = 5'(raw_len);
            end
            KIND_FLUSH:
            begin
                first.op = ENT_FLUSH;
            end
            default:
            begin
                first = '{op: ENT_CHUNK, len: '0, bits: '0, fin: 1'b1};
            end
        endcase
    end

    always_comb
    begin
        if (pend_valid_reg)
        begin
            push       = !q_full;
            push_entry = pend_entry_reg;
        end
        else
        begin
            push       = accept && (in_item.kind != KIND_SKIP);
            push_entry = first;
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_entry_next = pend_entry_reg;
        if (pend_valid_reg && !q_full)
        begin
            pend_valid_next = 1'b0;
        end
        if (accept && split)
        begin
            pend_valid_next = 1'b1;
            pend_entry_next = second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_entry_reg <= pend_entry_next;
    end

endmodule

/* rtl/obp_queue.sv */
// Short queue of bit runs between the front and back ends.
// Depends on obp_pkg.
module obp_queue import obp_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   q_valid,
    output entry_t q_entry
);

    entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("queue read while empty");

endmodule

/* rtl/obp_back.sv */
// Back end: packs bit runs into the 27-bit stock, holds emitted words until their
// last mark is known, and serializes them as words or parity bytes. Depends on obp_pkg.
module obp_back import obp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      word_mode,
    input  logic      q_valid,
    input  entry_t    q_entry,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic [STOCK_W-1:0] stock_reg;
    logic [STOCK_W-1:0] stock_next;
    logic [4:0]         count_reg;
    logic [4:0]         count_next;

    logic               p_valid_reg;
    logic               p_valid_next;
    logic               p_done_reg;
    logic               p_done_next;
    logic               p_fin_reg;
    logic               p_fin_next;
    logic [STOCK_W-1:0] p_word_reg;
    logic [STOCK_W-1:0] p_word_next;

    logic               s_valid_reg;
    logic               s_valid_next;
    logic               s_fin_reg;
    logic               s_fin_next;
    logic [1:0]         s_idx_reg;
    logic [1:0]         s_idx_next;
    logic [STOCK_W-1:0] s_word_reg;
    logic [STOCK_W-1:0] s_word_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    out_item_t          out_item_reg;
    out_item_t          out_item_next;

    logic [5:0]         sum;
    logic [51:0]        sh;
    logic               emit;
    logic [STOCK_W-1:0] emit_word;
    logic [STOCK_W-1:0] chunk_stock;
    logic [STOCK_W-1:0] new_stock;
    logic [4:0]         new_count;
    logic               out_load;
    logic               s_piece_last;
    logic               s_fire;
    logic               s_free;
    logic               p_held;
    logic               p_move;
    logic               blocked;
    logic [STOCK_W-1:0] piece;

    assign sum         = 6'(count_reg) + 6'(q_entry.len);
    assign sh          = 52'(q_entry.bits) << count_reg;
    assign chunk_stock = stock_reg | sh[STOCK_W-1:0];

    always_comb
    begin
        if (q_entry.op == ENT_FLUSH)
        begin
            emit      = (stock_reg != '0);
            emit_word = stock_reg;
            new_stock = '0;
            new_count = emit ? 5'd1 : count_reg;
        end
        else
        begin
            emit      = (sum > 6'd27);
            emit_word = chunk_stock;
            new_stock = emit ? 27'(sh[51:27]) : chunk_stock;
            new_count = emit ? 5'(sum - 6'd27) : 5'(sum);
        end
    end

    assign out_load     = !out_valid_reg || !out_stall;
    assign s_piece_last = word_mode || (s_idx_reg == 2'd3);
    assign s_fire       = s_valid_reg && out_load;
    assign s_free       = !s_valid_reg || (s_fire && s_piece_last);
    assign p_held       = p_valid_reg && !p_done_reg;
    assign p_move       = p_valid_reg && p_done_reg && s_free;
    assign blocked      = (p_valid_reg && p_done_reg && !s_free) || (emit && p_held && !s_free);
    assign pop          = q_valid && !blocked;

    always_comb
    begin
        if (word_mode)
        begin
            piece = s_word_reg;
        end
        else
        begin
            case (s_idx_reg)
                2'd0:    piece = 27'(s_word_reg[6:0]);
                2'd1:    piece = 27'(s_word_reg[13:7]);
                2'd2:    piece = 27'(s_word_reg[20:14]);
                default: piece = 27'({s_word_reg[26:21], ~^s_word_reg});
            endcase
        end
    end

    always_comb
    begin
        stock_next   = stock_reg;
        count_next   = count_reg;
        p_valid_next = p_valid_reg;
        p_done_next  = p_done_reg;
        p_fin_next   = p_fin_reg;
        p_word_next  = p_word_reg;
        s_valid_next = s_valid_reg;
        s_fin_next   = s_fin_reg;
        s_idx_next   = s_idx_reg;
        s_word_next  = s_word_reg;

        if (s_fire)
        begin
            if (s_piece_last)
            begin
                s_valid_next = 1'b0;
                s_idx_next   = 2'd0;
            end
            else
            begin
                s_idx_next = s_idx_reg + 2'd1;
            end
        end

        if (p_move)
        begin
            p_valid_next = 1'b0;
            s_valid_next = 1'b1;
            s_word_next  = p_word_reg;
            s_fin_next   = p_fin_reg;
            s_idx_next   = 2'd0;
        end

        if (pop)
        begin
            stock_next = new_stock;
            count_next = new_count;
            if (emit)
            begin
                // An older held word is now known not to be the item's last.
                if (p_held)
                begin
                    s_valid_next = 1'b1;
                    s_word_next  = p_word_reg;
                    s_fin_next   = 1'b0;
                    s_idx_next   = 2'd0;
                end
                p_valid_next = 1'b1;
                p_word_next  = emit_word;
                p_done_next  = q_entry.fin;
                p_fin_next   = q_entry.fin;
            end
            else if (q_entry.fin && p_held)
            begin
                p_done_next = 1'b1;
                p_fin_next  = 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_load)
        begin
            out_valid_next     = s_valid_reg;
            out_item_next.data = piece;
            out_item_next.last = s_fin_reg && s_piece_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stock_reg     <= '0;
            count_reg     <= '0;
            p_valid_reg   <= 1'b0;
            p_done_reg    <= 1'b0;
            p_fin_reg     <= 1'b0;
            s_valid_reg   <= 1'b0;
            s_fin_reg     <= 1'b0;
            s_idx_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            stock_reg     <= stock_next;
            count_reg     <= count_next;
            p_valid_reg   <= p_valid_next;
            p_done_reg    <= p_done_next;
            p_fin_reg     <= p_fin_next;
            s_valid_reg   <= s_valid_next;
            s_fin_reg     <= s_fin_next;
            s_idx_reg     <= s_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_word_reg   <= p_word_next;
        s_word_reg   <= s_word_next;
        out_item_reg <= out_item_next;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_reg <= 5'd27)
        else $error("pending bit count above word size");
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_entry.op == ENT_FLUSH && stock_reg != '0) |=> (stock_reg == '0 && count_reg == 5'd1))
        else $error("flush did not clear the stock");

endmodule

/* rtl/object_code_bit_packer.sv */
// Top level of the object-code bit packer: front end, run queue and back end.
// Depends on obp_pkg, obp_front, obp_queue and obp_back.
//
// The packer turns each input item into variable-length prefix codes and packs them
// least significant bit first into 27-bit words; a word goes out once more than 27 bits
// are pending, either whole (word_mode = 1) or as three 7-bit groups followed by the top
// six bits with an odd-parity bit (word_mode = 0). The front end accepts one item per
// cycle unless stalled and folds its codes into one bit run, except an instruction
// item whose opcode and upper word miss the pair table, which needs two runs and stalls
// the input until both are pushed. The back end adds one run to the stock per cycle
// unless blocked downstream, so with no stall the sustained rate is one item per cycle,
// lower for unmatched items. The output register delivers one result per cycle while
// out_stall is low, which sets the limit when words are emitted as bytes: four results
// per word. The last flag of a result is known only when the item's final run has been
// packed, so an emitted word waits in a holding register for that decision.
// Configuration is a single write-only bit written with cfg_write_en.
module object_code_bit_packer import obp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic   word_mode_reg;
    logic   word_mode_next;
    logic   q_full;
    logic   push;
    entry_t push_entry;
    logic   pop;
    logic   q_valid;
    entry_t q_entry;

    // Word mode defaults to byte output after reset.
    assign word_mode_next = cfg_write_en ? cfg_write_data : word_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_mode_reg <= 1'b0;
        end
        else
        begin
            word_mode_reg <= word_mode_next;
        end
    end

    obp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    obp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    obp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .word_mode (word_mode_reg),
        .q_valid   (q_valid),
        .q_entry   (q_entry),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
